// ----- sv/ctf_pkg.sv -----
// Package for the complementary tilt filter: payload structs, register codes,
// CORDIC arctangent table and controller/datapath command types. No dependencies.
package ctf_pkg;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] pitch_out;
        logic signed [31:0] roll_out;
        logic               corrected;
        logic               saturated;
    } t_out_beat;

    // register indexes
    localparam logic [1:0] REG_GYRO_GAIN = 2'd0;
    localparam logic [1:0] REG_MAG_LOW   = 2'd1;
    localparam logic [1:0] REG_MAG_HIGH  = 2'd2;
    localparam logic [1:0] REG_WEIGHT    = 2'd3;

    localparam int TAB_FRAC = 24;
    localparam int TAB_LEN  = 24;
    // CORDIC work width: 16-bit input scaled by 2^16, plus growth
    localparam int CW = 36;
    localparam int ZW = 36;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd754974720;
            5'd1:  v = 30'd445687602;
            5'd2:  v = 30'd235489088;
            5'd3:  v = 30'd119537938;
            5'd4:  v = 30'd60000934;
            5'd5:  v = 30'd30029717;
            5'd6:  v = 30'd15018523;
            5'd7:  v = 30'd7509720;
            5'd8:  v = 30'd3754917;
            5'd9:  v = 30'd1877466;
            5'd10: v = 30'd938734;
            5'd11: v = 30'd469367;
            5'd12: v = 30'd234684;
            5'd13: v = 30'd117342;
            5'd14: v = 30'd58671;
            5'd15: v = 30'd29335;
            5'd16: v = 30'd14668;
            5'd17: v = 30'd7334;
            5'd18: v = 30'd3667;
            5'd19: v = 30'd1833;
            5'd20: v = 30'd917;
            5'd21: v = 30'd458;
            5'd22: v = 30'd229;
            5'd23: v = 30'd115;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // datapath commands from the controller
    typedef struct packed {
        logic load;        // capture the sample, start gyro products
        logic integrate;   // add gyro products, saturate, check magnitude
        logic cordic_init; // set up CORDIC for pitch (sel=0) or roll (sel=1)
        logic cordic_step; // one CORDIC rotation
        logic blend_mul;   // form the two blend products
        logic blend_sum;   // sum, round, write the angle
        logic axis_sel;    // 0 pitch, 1 roll
        logic emit;        // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic correct;     // magnitude in window
        logic cordic_last; // current step is the final one
    } t_dp_stat;

endpackage

// ----- sv/ctf_ctrl.sv -----
// Controller for the complementary tilt filter: sequences load, integrate,
// the per-axis CORDIC and blend, and output. Uses ctf_pkg.
module ctf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_out_busy,
    input  ctf_pkg::t_dp_stat  i_stat,
    output ctf_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_INTEG = 8'b0000_0010,
        S_CINIT = 8'b0000_0100,
        S_CSTEP = 8'b0000_1000,
        S_BMUL  = 8'b0001_0000,
        S_BSUM  = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_MULT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_axis, n_axis;

    assign o_in_stall = (r_state != S_IDLE);

    // advance the sequence
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.axis_sel = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MULT;
                end
            end
            S_MULT: n_state = S_INTEG;
            S_INTEG: begin
                o_cmd.integrate = 1'b1;
                n_axis = 1'b0;
                n_state = i_stat.correct ? S_CINIT : S_EMIT;
            end
            S_CINIT: begin
                o_cmd.cordic_init = 1'b1;
                n_state = S_CSTEP;
            end
            S_CSTEP: begin
                o_cmd.cordic_step = 1'b1;
                if (i_stat.cordic_last) n_state = S_BMUL;
            end
            S_BMUL: begin
                o_cmd.blend_mul = 1'b1;
                n_state = S_BSUM;
            end
            S_BSUM: begin
                o_cmd.blend_sum = 1'b1;
                if (r_axis) begin
                    n_state = S_EMIT;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_CINIT;
                end
            end
            S_EMIT: begin
                if (!i_out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    // a new beat only enters from idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> r_state == S_IDLE)
        else $error("load outside idle");
    // CORDIC always starts right after its setup
    a_cinit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.cordic_init |=> r_state == S_CSTEP)
        else $error("cordic setup not followed by steps");
    // roll blend ends the corrected sequence
    a_roll_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.blend_sum && r_axis) |=> r_state == S_EMIT)
        else $error("roll blend not followed by emit");

endmodule

// ----- sv/ctf_dp.sv -----
// Datapath for the complementary tilt filter: angle accumulators, gyro
// integration, shared iterative CORDIC and blend multipliers. Uses ctf_pkg.
module ctf_dp #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ctf_pkg::t_in_beat  i_in,
    input  ctf_pkg::t_dp_cmd   i_cmd,
    output ctf_pkg::t_dp_stat  o_stat,
    input  logic [15:0]        i_gain,
    input  logic [16:0]        i_mag_low,
    input  logic [16:0]        i_mag_high,
    input  logic [16:0]        i_weight,
    output ctf_pkg::t_out_beat o_res
);

    localparam int CW  = ctf_pkg::CW;
    localparam int ZW  = ctf_pkg::ZW;
    localparam int SH  = ctf_pkg::TAB_FRAC - ANGLE_FRAC_BITS;
    localparam int SW  = $clog2(CORDIC_STEPS);
    localparam logic [SW-1:0] LAST = SW'(CORDIC_STEPS - 1);

    ctf_pkg::t_in_beat r_smp;
    logic signed [31:0] r_pitch, r_roll;
    logic signed [32:0] r_gx_prod, r_gy_prod;
    logic               r_sat, r_corr;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [SW-1:0]      r_i;
    logic               r_zero;     // numerator zero: fixed result
    logic signed [ZW-1:0] r_zfix;
    logic signed [49:0] r_pa, r_pb;
    ctf_pkg::t_out_beat r_res;

    // integration sums and saturation
    logic signed [33:0] p_sum, r_sum_i;
    logic p_sat, q_sat;
    logic signed [31:0] p_clip, q_clip;
    always_comb begin
        p_sum   = 34'(r_pitch) + 34'(r_gx_prod);
        r_sum_i = 34'(r_roll) - 34'(r_gy_prod);
        p_sat = (p_sum > 34'sh07FFFFFFF) || (p_sum < -34'sh080000000);
        q_sat = (r_sum_i > 34'sh07FFFFFFF) || (r_sum_i < -34'sh080000000);
        p_clip = (p_sum > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                 (p_sum < -34'sh080000000) ? 32'sh80000000 : p_sum[31:0];
        q_clip = (r_sum_i > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                 (r_sum_i < -34'sh080000000) ? 32'sh80000000 : r_sum_i[31:0];
    end

    // accel magnitude window
    logic [17:0] mag;
    logic [15:0] abs_x, abs_y, abs_z;
    always_comb begin
        abs_x = r_smp.accel_x[15] ? 16'(-r_smp.accel_x) : r_smp.accel_x;
        abs_y = r_smp.accel_y[15] ? 16'(-r_smp.accel_y) : r_smp.accel_y;
        abs_z = r_smp.accel_z[15] ? 16'(-r_smp.accel_z) : r_smp.accel_z;
        mag = 18'(abs_x) + 18'(abs_y) + 18'(abs_z);
    end
    assign o_stat.correct     = (mag > 18'(i_mag_low)) && (mag < 18'(i_mag_high));
    assign o_stat.cordic_last = (r_i == LAST);

    // CORDIC setup with quadrant turn
    logic signed [15:0] num, den;
    logic signed [CW-1:0] x0, y0, xs, ys;
    logic signed [ZW-1:0] z0;
    always_comb begin
        num = i_cmd.axis_sel ? r_smp.accel_x : r_smp.accel_y;
        den = r_smp.accel_z;
        xs = CW'(den) <<< 16;
        ys = CW'(num) <<< 16;
        x0 = xs; y0 = ys; z0 = '0;
        if (den[15]) begin
            if (!num[15]) begin
                x0 = ys; y0 = -xs; z0 = ZW'(90) <<< ctf_pkg::TAB_FRAC;
            end else begin
                x0 = -ys; y0 = xs; z0 = -(ZW'(90) <<< ctf_pkg::TAB_FRAC);
            end
        end
    end

    // one CORDIC rotation
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    logic                 ypos;
    always_comb begin
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        at = ZW'(ctf_pkg::atan_entry(5'(r_i)));
        ypos = (r_y > 0);
    end

    // rounded CORDIC angle
    logic signed [ZW-1:0] z_rnd, acc_ang;
    always_comb begin
        z_rnd   = (r_z + (ZW'(1) <<< (SH - 1))) >>> SH;
        acc_ang = r_zero ? r_zfix : z_rnd;
    end

    // blend weight clamp and product inputs
    logic [16:0] w;
    logic signed [31:0] cur;
    logic signed [49:0] bsum;
    always_comb begin
        w   = (i_weight > 17'd65536) ? 17'd65536 : i_weight;
        cur = i_cmd.axis_sel ? r_roll : r_pitch;
        bsum = r_pa + r_pb + 50'sd32768;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= '0;
            r_roll  <= '0;
        end else begin
            if (i_cmd.integrate) begin
                r_pitch <= p_clip;
                r_roll  <= q_clip;
            end else if (i_cmd.blend_sum) begin
                if (i_cmd.axis_sel) r_roll  <= bsum[47:16];
                else                r_pitch <= bsum[47:16];
            end
        end
    end

    // payload: sample, products, CORDIC, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_smp <= i_in;
        r_gx_prod <= r_smp.gyro_x * $signed({1'b0, i_gain});
        r_gy_prod <= r_smp.gyro_y * $signed({1'b0, i_gain});
        if (i_cmd.integrate) begin
            r_sat  <= p_sat | q_sat;
            r_corr <= o_stat.correct;
        end
        if (i_cmd.cordic_init) begin
            r_x <= x0; r_y <= y0; r_z <= z0; r_i <= '0;
            r_zero <= (num == 16'sd0);
            r_zfix <= den[15] ? (ZW'(180) <<< ANGLE_FRAC_BITS) : '0;
        end else if (i_cmd.cordic_step) begin
            r_i <= r_i + 1'b1;
            if (ypos) begin
                r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + at;
            end else begin
                r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - at;
            end
        end
        if (i_cmd.blend_mul) begin
            r_pa <= 50'(cur) * $signed({1'b0, w});
            r_pb <= 50'(acc_ang) * $signed(18'(18'd65536 - 18'(w)));
        end
        if (i_cmd.emit) begin
            r_res.pitch_out <= r_pitch;
            r_res.roll_out  <= r_roll;
            r_res.corrected <= r_corr;
            r_res.saturated <= r_sat;
        end
    end

    assign o_res = r_res;

    // CORDIC index stays within its step count
    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cordic_step |-> r_i <= LAST)
        else $error("cordic index out of range");
    // CORDIC only starts once the corrected flag is set (flag captured with window)
    a_corr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cordic_init |-> r_corr)
        else $error("cordic started without correction");
    // integrate and blend never write the angles together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.integrate && i_cmd.blend_sum))
        else $error("angle write conflict");

endmodule

// ----- sv/complementary_tilt_filter.sv -----
// Top level of the complementary tilt filter: config registers, output
// handshake, controller and datapath. Uses ctf_pkg, ctf_ctrl, ctf_dp.
//
//  channel | direction | handshake             | payload
//  in      | input     | i_in_valid/o_in_stall | ctf_pkg::t_in_beat
//  out     | output    | o_out_valid/i_out_stall | ctf_pkg::t_out_beat
//  cfg     | input     | APB psel/penable      | 32-bit register data
//
// An uncorrected beat passes the product, integrate and emit states. A corrected
// one also runs CORDIC setup, the CORDIC steps, blend multiply and blend sum for
// each axis, so it holds the input longer, and its result comes later; this is
// set by the single shared CORDIC iterated per axis.
// One beat is in work at a time; the output register frees the datapath as
// soon as a result is loaded, and a stalled result holds the next one in emit.
// Synchronous active-low reset zeroes both angles.
module complementary_tilt_filter #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ctf_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ctf_pkg::t_out_beat o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [15:0] r_gain;
    logic [16:0] r_mlow, r_mhigh, r_weight;
    logic        r_out_valid;
    ctf_pkg::t_dp_cmd  cmd;
    ctf_pkg::t_dp_stat stat;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= 16'd10;
            r_mlow   <= 17'd8192;
            r_mhigh  <= 17'd32768;
            r_weight <= 17'd64225;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                ctf_pkg::REG_GYRO_GAIN: r_gain   <= pwdata[15:0];
                ctf_pkg::REG_MAG_LOW:   r_mlow   <= pwdata[16:0];
                ctf_pkg::REG_MAG_HIGH:  r_mhigh  <= pwdata[16:0];
                ctf_pkg::REG_WEIGHT:    r_weight <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            ctf_pkg::REG_GYRO_GAIN: prdata = 32'(r_gain);
            ctf_pkg::REG_MAG_LOW:   prdata = 32'(r_mlow);
            ctf_pkg::REG_MAG_HIGH:  prdata = 32'(r_mhigh);
            ctf_pkg::REG_WEIGHT:    prdata = 32'(r_weight);
            default:                prdata = '0;
        endcase
    end

    // hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)       r_out_valid <= 1'b0;
        else if (cmd.emit)  r_out_valid <= 1'b1;
        else if (!i_out_stall) r_out_valid <= 1'b0;
    end
    assign o_out_valid = r_out_valid;

    ctf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_out_busy (r_out_valid && i_out_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ctf_dp #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_gain     (r_gain),
        .i_mag_low  (r_mlow),
        .i_mag_high (r_mhigh),
        .i_weight   (r_weight),
        .o_res      (o_out_data)
    );

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for complementary_tilt_filter: drives IMU sample beats,
// predicts pitch/roll with an in-bench fixed-point filter and CORDIC, checks results.
// Depends on ctf_pkg and the RTL top level.
module tb;

    localparam int STEPS     = 16;
    localparam int FRAC      = 16;
    localparam int WDOG_MAX  = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    ctf_pkg::t_in_beat  i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    ctf_pkg::t_out_beat o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state and register copies
    logic [15:0]        gain_q;
    logic [16:0]        mag_lo_q;
    logic [16:0]        mag_hi_q;
    logic [16:0]        weight_q;
    logic signed [31:0] pitch_q;
    logic signed [31:0] roll_q;

    ctf_pkg::t_out_beat angle_fifo[$];
    int        err_cnt;
    int        wdog;
    int        hold_off = 0;
    bit        done;
    bit        long_go;
    logic      long_hold;

    complementary_tilt_filter u_top (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic longint floor_sh(input longint v, input int s);
        return v >>> s;
    endfunction

    // atan2(num, den) in degrees, FRAC fraction bits
    function automatic longint tilt_deg(input longint num, input longint den);
        longint x, y, z, t, dx, dy;
        z = 0;
        if (num == 0) return (den >= 0) ? 0 : (longint'(180) <<< FRAC);
        x = den * 65536;
        y = num * 65536;
        if (x < 0) begin
            if (y > 0) begin
                t = x; x = y; y = -t;
                z = longint'(90) <<< ctf_pkg::TAB_FRAC;
            end else begin
                t = x; x = -y; y = t;
                z = -(longint'(90) <<< ctf_pkg::TAB_FRAC);
            end
        end
        for (int i = 0; i < STEPS && i < ctf_pkg::TAB_LEN; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += longint'(ctf_pkg::atan_entry(5'(i)));
            end else begin
                x -= dx; y += dy; z -= longint'(ctf_pkg::atan_entry(5'(i)));
            end
        end
        return floor_sh(z + (longint'(1) <<< (ctf_pkg::TAB_FRAC - FRAC - 1)),
                        ctf_pkg::TAB_FRAC - FRAC);
    endfunction

    function automatic logic signed [31:0] clip_angle(input longint v, inout bit sat);
        if (v > 64'sd2147483647) begin sat = 1; return 32'sh7fffffff; end
        if (v < -64'sd2147483648) begin sat = 1; return 32'sh80000000; end
        return 32'(v);
    endfunction

    function automatic logic signed [31:0] mix(input longint ang, input longint acc,
                                               input longint w);
        return 32'(floor_sh(ang * w + acc * (65536 - w) + 32768, 16));
    endfunction

    // advance the filter model by one sample and queue the expected result
    task automatic predict_tilt(input ctf_pkg::t_in_beat b);
        ctf_pkg::t_out_beat r;
        bit sat, corr;
        longint mag, w, g;
        sat = 0;
        corr = 0;
        g = longint'(gain_q);
        pitch_q = clip_angle(longint'(pitch_q) + longint'(b.gyro_x) * g, sat);
        roll_q  = clip_angle(longint'(roll_q) - longint'(b.gyro_y) * g, sat);
        mag = (b.accel_x < 0 ? -longint'(b.accel_x) : longint'(b.accel_x))
            + (b.accel_y < 0 ? -longint'(b.accel_y) : longint'(b.accel_y))
            + (b.accel_z < 0 ? -longint'(b.accel_z) : longint'(b.accel_z));
        if (mag > longint'(mag_lo_q) && mag < longint'(mag_hi_q)) begin
            w = longint'(weight_q);
            if (w > 65536) w = 65536;
            pitch_q = mix(pitch_q, tilt_deg(b.accel_y, b.accel_z), w);
            roll_q  = mix(roll_q, tilt_deg(b.accel_x, b.accel_z), w);
            corr = 1;
        end
        r.pitch_out = pitch_q;
        r.roll_out  = roll_q;
        r.corrected = corr;
        r.saturated = sat;
        angle_fifo.push_back(r);
    endtask

    // send one sample beat, with a random gap first; valid drops only in a gap
    task automatic send_sample(input ctf_pkg::t_in_beat b);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_tilt(b);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ctf_pkg::REG_GYRO_GAIN: gain_q   = val[15:0];
            ctf_pkg::REG_MAG_LOW:   mag_lo_q = val[16:0];
            ctf_pkg::REG_MAG_HIGH:  mag_hi_q = val[16:0];
            default:                weight_q = val[16:0];
        endcase
        @(posedge i_clk);
    endtask

    // drop valid, wait until every result is back, then let the datapath settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (angle_fifo.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic ctf_pkg::t_in_beat rand_beat();
        ctf_pkg::t_in_beat b;
        b = ctf_pkg::t_in_beat'(80'({$urandom, $urandom, $urandom}));
        return b;
    endfunction

    // a beat with accel magnitude inside the window most of the time
    function automatic ctf_pkg::t_in_beat tilt_beat();
        ctf_pkg::t_in_beat b;
        b = rand_beat();
        b.accel_x = 16'($signed($urandom_range(0, 12000)) - 6000);
        b.accel_y = 16'($signed($urandom_range(0, 12000)) - 6000);
        b.accel_z = 16'($signed($urandom_range(0, 20000)) - 10000);
        b.gyro_x  = 16'($signed($urandom_range(0, 2000)) - 1000);
        b.gyro_y  = 16'($signed($urandom_range(0, 2000)) - 1000);
        return b;
    endfunction

    function automatic ctf_pkg::t_in_beat mk(input int ax, ay, az, gx, gy);
        ctf_pkg::t_in_beat b;
        b.accel_x = 16'(ax); b.accel_y = 16'(ay); b.accel_z = 16'(az);
        b.gyro_x = 16'(gx); b.gyro_y = 16'(gy);
        return b;
    endfunction

    // directed: zero numerators, negative denominators, field extremes, saturation
    task automatic test_directed();
        send_sample(mk(0, 0, 16000, 0, 0));
        send_sample(mk(0, 0, -16000, 100, -100));
        send_sample(mk(9000, 9000, -9000, 0, 0));
        send_sample(mk(-9000, -9000, -9000, 0, 0));
        send_sample(mk(12000, -12000, 0, 0, 0));
        send_sample(mk(-15000, 15000, 1, 0, 0));
        send_sample(mk(32767, 32767, 32767, 32767, 32767));
        send_sample(mk(-32768, -32768, -32768, -32768, -32768));
        send_sample(mk(4096, 4096, 0, 1, -1));
        send_sample(mk(4097, 4096, 0, 0, 0));
        drain();
        write_reg(ctf_pkg::REG_GYRO_GAIN, 32'd65535);
        write_reg(ctf_pkg::REG_MAG_LOW, 32'd98304);
        for (int i = 0; i < 8; i++) send_sample(mk(0, 0, 0, 32767, -32768));
        for (int i = 0; i < 8; i++) send_sample(mk(0, 0, 0, -32768, 32767));
        drain();
    endtask

    // sweep register settings, with mostly tilt_beat samples (two settings leave the window empty)
    task automatic test_settings();
        logic [31:0] gains[4]   = '{32'd0, 32'd10, 32'd300, 32'd65535};
        logic [31:0] weights[4] = '{32'd0, 32'd64225, 32'd65536, 32'd131071};
        for (int p = 0; p < 4; p++) begin
            write_reg(ctf_pkg::REG_GYRO_GAIN, gains[p]);
            write_reg(ctf_pkg::REG_MAG_LOW, (p == 3) ? 32'd131071 : 32'd0 + p * 100);
            write_reg(ctf_pkg::REG_MAG_HIGH, (p == 2) ? 32'd0 : 32'd98304 + p * 1000);
            write_reg(ctf_pkg::REG_WEIGHT, weights[p]);
            for (int i = 0; i < 60; i++)
                send_sample(($urandom_range(0, 4) != 0) ? tilt_beat() : rand_beat());
            drain();
        end
    endtask

    // random bulk with default-like window and noise
    task automatic test_random();
        write_reg(ctf_pkg::REG_GYRO_GAIN, 32'd10);
        write_reg(ctf_pkg::REG_MAG_LOW, 32'd8192);
        write_reg(ctf_pkg::REG_MAG_HIGH, 32'd32768);
        write_reg(ctf_pkg::REG_WEIGHT, 32'd64225);
        for (int i = 0; i < 700; i++) begin
            if (i == 100) long_go = 1'b1;
            send_sample(($urandom_range(0, 3) != 0) ? tilt_beat() : rand_beat());
        end
        drain();
    endtask

    // long receiver hold-off, counted here once requested
    initial begin
        long_hold = 1'b0;
        @(posedge i_clk iff long_go);
        long_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // result sink: random stalls, long hold-off on request, checking
    always @(posedge i_clk) begin
        ctf_pkg::t_out_beat e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (angle_fifo.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    e = angle_fifo.pop_front();
                    if (o_out_data.pitch_out !== e.pitch_out)
                        report("pitch_out", o_out_data.pitch_out, e.pitch_out);
                    if (o_out_data.roll_out !== e.roll_out)
                        report("roll_out", o_out_data.roll_out, e.roll_out);
                    if (o_out_data.corrected !== e.corrected)
                        report("corrected", o_out_data.corrected, e.corrected);
                    if (o_out_data.saturated !== e.saturated)
                        report("saturated", o_out_data.saturated, e.saturated);
                end
            end
            if (long_hold) begin
                i_out_stall <= 1'b1;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                i_out_stall <= 1'b1;
            end else if ($urandom_range(0, 49) == 0) begin
                hold_off <= $urandom_range(10, 80);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX && !done) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        err_cnt = 0;
        wdog = 0;
        done = 0;
        long_go = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        gain_q = 16'd10;
        mag_lo_q = 17'd8192;
        mag_hi_q = 17'd32768;
        weight_q = 17'd64225;
        pitch_q = '0;
        roll_q = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_settings();
        test_random();
        done = 1;
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ----- complementary_tilt_filter.f -----
sv/ctf_pkg.sv
sv/ctf_ctrl.sv
sv/ctf_dp.sv
sv/complementary_tilt_filter.sv
dv/tb.sv
